// File: src/u2a_pkg.sv
package u2a_pkg;

    // Width of the value field on the input port.
    localparam int FIELD_WIDTH = 32;

    // Input mode codes.
    typedef enum logic [1:0] {
        MODE_DEC    = 2'd0,
        MODE_OCT    = 2'd1,
        MODE_HEX_LO = 2'd2,
        MODE_HEX_UP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    // Classified conversion request, as the front hands it to the back.
    typedef struct packed {
        radix_t radix;
        logic   upper;
    } cls_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_NINE = 7'h39;
    localparam logic [6:0] CHAR_UP_A = 7'h41;
    localparam logic [6:0] CHAR_UP_F = 7'h46;
    localparam logic [6:0] CHAR_LO_A = 7'h61;
    localparam logic [6:0] CHAR_LO_F = 7'h66;

    localparam logic [3:0] TEN = 4'd10;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every v below 2**32.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? CHAR_UP_A : CHAR_LO_A;
        if (d < TEN) begin
            return CHAR_ZERO + 7'(d);
        end
        return base + 7'(d) - 7'(TEN);
    endfunction

endpackage

// File: src/u2a_queue.sv
module u2a_queue #(
    parameter int WIDTH = 35
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/u2a_front.sv
module u2a_front #(
    parameter int EFF_W = 32
) (
    input  logic [u2a_pkg::FIELD_WIDTH-1:0] value,
    input  logic [1:0]                      mode,
    input  logic                            num_valid,
    output logic                            num_stall,
    output logic                            push,
    output logic [EFF_W-1:0]                push_value,
    output u2a_pkg::cls_t                   push_cls,
    input  logic                            full
);

    import u2a_pkg::*;

    // Items wait here only while the queue toward the converter is full.
    assign num_stall  = full;
    assign push       = num_valid && !full;
    assign push_value = value[EFF_W-1:0];

    always_comb
    begin
        unique case (mode_t'(mode))
            MODE_DEC:    push_cls = '{radix: RADIX_DEC, upper: 1'b0};
            MODE_OCT:    push_cls = '{radix: RADIX_OCT, upper: 1'b0};
            MODE_HEX_LO: push_cls = '{radix: RADIX_HEX, upper: 1'b0};
            MODE_HEX_UP: push_cls = '{radix: RADIX_HEX, upper: 1'b1};
        endcase
    end

endmodule

// File: src/u2a_back.sv
module u2a_back #(
    parameter int EFF_W      = 32,
    parameter int MAX_DIGITS = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [EFF_W-1:0] q_value,
    input  u2a_pkg::cls_t    q_cls,
    output logic             pop,
    output logic             char_valid,
    input  logic             char_stall,
    output logic [6:0]       ascii_char,
    output logic             last
);

    import u2a_pkg::*;

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [EFF_W-1:0] val_reg;
    logic [EFF_W-1:0] val_next;
    cls_t             cls_reg;
    cls_t             cls_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [3:0]       buf_reg [MAX_DIGITS];
    logic             buf_we;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [6:0]       char_reg;
    logic [6:0]       char_next;
    logic             last_reg;
    logic             last_next;

    logic [63:0]      prod;
    logic [28:0]      q_dec_raw;
    logic [EFF_W-1:0] q_dec;
    logic [EFF_W-1:0] rem_dec;
    logic [EFF_W-1:0] quot;
    logic [3:0]       digit;
    logic [CW-1:0]    cnt_dec;
    logic             emit_ok;

    // One digit per cycle, least significant first.
    assign prod      = {32'b0, 32'(val_reg)} * {32'b0, RECIP_TEN};
    assign q_dec_raw = prod[63:RECIP_SHIFT];
    assign q_dec     = EFF_W'(q_dec_raw);
    assign rem_dec   = val_reg - ((q_dec << 3) + (q_dec << 1));

    always_comb
    begin
        unique case (cls_reg.radix)
            RADIX_DEC:
            begin
                quot  = q_dec;
                digit = rem_dec[3:0];
            end
            RADIX_OCT:
            begin
                quot  = val_reg >> 3;
                digit = {1'b0, val_reg[2:0]};
            end
            default:
            begin
                quot  = val_reg >> 4;
                digit = val_reg[3:0];
            end
        endcase
    end

    assign cnt_dec = cnt_reg - CW'(1);
    assign emit_ok = !out_valid_reg || !char_stall;

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        cls_next       = cls_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;
        buf_we         = 1'b0;
        out_valid_next = out_valid_reg && char_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    val_next   = q_value;
                    cls_next   = q_cls;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                buf_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                val_next = quot;
                if (quot == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(buf_reg[cnt_dec[IW-1:0]], cls_reg.upper);
                    last_next      = (cnt_reg == CW'(1));
                    cnt_next       = cnt_dec;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        cls_reg  <= cls_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (buf_we)
        begin
            buf_reg[cnt_reg[IW-1:0]] <= digit;
        end
    end

    assign char_valid = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DIGITS))
        else $error("digit count exceeds buffer depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg != '0)
        else $error("emitting with an empty digit buffer");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_ok && cnt_reg == CW'(1))
        |=> (state_reg == ST_IDLE && char_valid && last))
        else $error("final character not flagged or converter not idle");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE)
                     || (ascii_char >= CHAR_LO_A && ascii_char <= CHAR_LO_F)
                     || (ascii_char >= CHAR_UP_A && ascii_char <= CHAR_UP_F)))
        else $error("character outside the digit set");
`endif

endmodule

// File: src/unsigned_to_ascii_radix.sv
// Converts an unsigned number into its ASCII digits in decimal, octal,
// lowercase hex or uppercase hex, selected per item by mode, and sends them
// out one character per item, most significant digit first, without leading
// zeros; a zero value gives the single character '0', and last marks the
// final character of each number. Only the low VALUE_WIDTH bits of value are
// used (at most 32). An accepted number goes into a two-entry queue and then
// to a converter that produces one digit per cycle, least significant first,
// into a small digit buffer, and afterwards reads that buffer back in reverse
// through the output register. For each number the converter loads it,
// converts it with one divide-by-radix step per digit and then emits its
// digits, holding while the output is stalled; it takes the next number
// from the queue only once it is idle again. The queue lets two further
// numbers be accepted while a conversion runs.
module unsigned_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            num_valid,
    output logic                            num_stall,
    input  logic [u2a_pkg::FIELD_WIDTH-1:0] value,
    input  logic [1:0]                      mode,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [6:0]                      ascii_char,
    output logic                            last
);

    import u2a_pkg::*;

    // Bits that take part in the conversion, and the longest digit run
    // they can produce (octal gives the most digits).
    localparam int EFF_W      = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
    localparam int MAX_DIGITS = (EFF_W + 2) / 3;
    localparam int QW         = EFF_W + $bits(cls_t);

    logic             push;
    logic [EFF_W-1:0] push_value;
    cls_t             push_cls;
    logic             full;
    logic             pop;
    logic [QW-1:0]    pop_data;
    logic             empty;
    logic [EFF_W-1:0] q_value;
    cls_t             q_cls;

    // The front masks the value and turns the mode into a radix and a case.
    u2a_front #(
        .EFF_W (EFF_W)
    ) u_front (
        .value      (value),
        .mode       (mode),
        .num_valid  (num_valid),
        .num_stall  (num_stall),
        .push       (push),
        .push_value (push_value),
        .push_cls   (push_cls),
        .full       (full)
    );

    // The queue decouples acceptance from the converter.
    u2a_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cls, push_value}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    assign q_value = pop_data[EFF_W-1:0];
    assign q_cls   = cls_t'(pop_data[QW-1:EFF_W]);

    // The back converts one number at a time and drives the output.
    u2a_back #(
        .EFF_W      (EFF_W),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .q_value    (q_value),
        .q_cls      (q_cls),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

// File: test/tb_unsigned_to_ascii_radix.sv
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_radix;

    import u2a_pkg::*;

    // Cycles without any accepted item before the run is declared hung. The
    // slowest correct case is an eleven-digit octal number behind a receiver
    // that stalls more than half the time, which stays far below this.
    localparam int QUIET_LIMIT = 5000;

    // Cycles to watch for stray characters once nothing is expected. The
    // window allows for the longest conversion, an eleven-digit octal number,
    // while the block holds two more numbers in its queue.
    localparam int TAIL_CYCLES = 80;

    localparam int RANDOM_PER_PHASE = 50;

    localparam byte DIGIT_ZERO = "0";
    localparam byte LETTER_LO  = "a";
    localparam byte LETTER_UP  = "A";

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } ascii_digit_t;

    // Predicts the digit string of each accepted number and checks the
    // characters that leave the block against it, oldest first.
    class ascii_digit_board;
        ascii_digit_t pending_digits[$];
        int           failures;

        function void note_number(logic [FIELD_WIDTH-1:0] number, mode_t radix_mode);
            logic [FIELD_WIDTH-1:0] rest;
            logic [3:0]             digit;
            logic [6:0]             text[$];
            ascii_digit_t           entry;
            rest = number;
            // A do-while gives a zero value its single '0' digit for free.
            do
            begin
                case (radix_mode)
                    MODE_DEC:
                    begin
                        digit = 4'(rest % 10);
                        rest  = rest / 10;
                    end
                    MODE_OCT:
                    begin
                        digit = {1'b0, rest[2:0]};
                        rest  = rest >> 3;
                    end
                    default:
                    begin
                        digit = rest[3:0];
                        rest  = rest >> 4;
                    end
                endcase
                if (digit < 10)
                    text.push_front(7'(DIGIT_ZERO + digit));
                else if (radix_mode == MODE_HEX_UP)
                    text.push_front(7'(LETTER_UP + digit - 10));
                else
                    text.push_front(7'(LETTER_LO + digit - 10));
            end
            while (rest != 0);
            foreach (text[i])
            begin
                entry.ch   = text[i];
                entry.last = (i == text.size() - 1);
                pending_digits.push_back(entry);
            end
        endfunction

        function void check_digit(logic [6:0] ch, logic last);
            ascii_digit_t want;
            if (pending_digits.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: character %h last %b arrived with none expected",
                             $realtime, ch, last);
                return;
            end
            want = pending_digits.pop_front();
            if (ch !== want.ch || last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                             $realtime, want.ch, want.last, ch, last);
            end
        endfunction

        function int outstanding();
            return pending_digits.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   num_valid;
    logic                   num_stall;
    logic [FIELD_WIDTH-1:0] value;
    logic [1:0]             mode;
    logic                   char_valid;
    logic                   char_stall;
    logic [6:0]             ascii_char;
    logic                   last;

    ascii_digit_board board;

    // Idling percentages of the current phase, read by the drivers.
    int send_idle_pct;
    int recv_stall_pct;

    // Advanced by the monitor each time a number is taken; the sender
    // compares it at the falling edge to see whether its item went in.
    int numbers_taken;
    int quiet_cycles;

    unsigned_to_ascii_radix DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_valid  (num_valid),
        .num_stall  (num_stall),
        .value      (value),
        .mode       (mode),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Every input has a known value from time zero; reset is released at a
    // falling edge and never asserted again.
    initial
    begin
        rst_n      = 1'b0;
        num_valid  = 1'b0;
        value      = '0;
        mode       = MODE_DEC;
        char_stall = 1'b0;
    end

    // The receiver decides its stall at each falling edge, so the value is
    // settled well before the rising edge that samples it.
    always @(negedge clk)
        char_stall <= ($urandom_range(99) < recv_stall_pct);

    // Both handshakes are sampled at the rising edge. A number goes into
    // the predictor the moment it is accepted, and each accepted character
    // is checked against the oldest outstanding digit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (num_valid && !num_stall)
            begin
                board.note_number(value, mode_t'(mode));
                numbers_taken++;
                quiet_cycles = 0;
            end
            if (char_valid && !char_stall)
            begin
                board.check_digit(ascii_char, last);
                quiet_cycles = 0;
            end
        end
    end

    // Presents one number and holds it until it is taken. Called and
    // returning at a falling edge; valid stays high on return so that
    // back-to-back numbers need no gap.
    task automatic send_number(input logic [FIELD_WIDTH-1:0] number, input mode_t radix_mode);
        int taken_before;
        while ($urandom_range(99) < send_idle_pct)
        begin
            num_valid <= 1'b0;
            @(negedge clk);
        end
        num_valid    <= 1'b1;
        value        <= number;
        mode         <= radix_mode;
        taken_before  = numbers_taken;
        do
            @(negedge clk);
        while (numbers_taken == taken_before);
    endtask

    // Drops valid and holds off until every predicted character is out.
    task automatic drain_digits();
        num_valid <= 1'b0;
        @(negedge clk);
        while (board.outstanding() != 0)
            @(negedge clk);
    endtask

    // Random values get a random significant length so that every digit
    // count shows up in every radix, with an occasional plain zero.
    task automatic send_random_number();
        logic [FIELD_WIDTH-1:0] number;
        int                     span;
        span   = $urandom_range(FIELD_WIDTH, 1);
        number = $urandom;
        if (span < FIELD_WIDTH)
            number = number & ((32'd1 << span) - 1);
        if ($urandom_range(15) == 0)
            number = '0;
        send_number(number, mode_t'($urandom_range(3)));
    endtask

    initial
    begin
        board          = new;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        numbers_taken  = 0;
        quiet_cycles   = 0;

        // Reset stays low through the rising edges below and is released at a falling edge.
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: zero in every radix, the all-ones value in every
        // radix (which gives the eleven-digit octal run), the boundaries
        // where one more digit appears, and hex letters in both cases.
        send_number(32'd0,          MODE_DEC);
        send_number(32'd0,          MODE_OCT);
        send_number(32'd0,          MODE_HEX_LO);
        send_number(32'd0,          MODE_HEX_UP);
        send_number(32'hFFFF_FFFF,  MODE_DEC);
        send_number(32'hFFFF_FFFF,  MODE_OCT);
        send_number(32'hFFFF_FFFF,  MODE_HEX_LO);
        send_number(32'hFFFF_FFFF,  MODE_HEX_UP);
        send_number(32'd9,          MODE_DEC);
        send_number(32'd10,         MODE_DEC);
        send_number(32'd7,          MODE_OCT);
        send_number(32'd8,          MODE_OCT);
        send_number(32'd15,         MODE_HEX_LO);
        send_number(32'd16,         MODE_HEX_UP);
        send_number(32'hABCD_EF10,  MODE_HEX_LO);
        send_number(32'hABCD_EF10,  MODE_HEX_UP);
        send_number(32'h8000_0000,  MODE_OCT);
        send_number(32'd1000000000, MODE_DEC);
        send_number(32'd999999999,  MODE_DEC);
        send_number(32'h4000_0000,  MODE_OCT);
        send_number(32'd1,          MODE_HEX_UP);
        send_number(32'h1234_5678,  MODE_DEC);
        drain_digits();

        // Random part in four idling phases: none, sender gaps, receiver
        // stalls, and both together. Each phase ends with a full drain, and
        // now and then the sender also waits for the block to empty.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 38 : 0;
            recv_stall_pct = (phase == 2) ? 58 : (phase == 3) ? 38 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if ($urandom_range(39) == 0)
                    drain_digits();
                send_random_number();
            end
            drain_digits();
        end

        // Anything that leaves the block from here on is unexpected.
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (board.outstanding() != 0)
            $display("%0d predicted characters never arrived", board.outstanding());
        if (board.failures == 0 && board.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a run in which neither side moves for too long is hung.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("no item accepted for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
